>>> design/plss_pkg.sv
package plss_pkg;

  localparam int Dims      = 4;
  localparam int CoordW    = 8;
  localparam int ExtW      = 9;
  localparam int StepW     = 16;
  localparam int MaxExtent = 256;
  localparam int ExtReset  = 8;
  localparam int DivSteps  = StepW;
  localparam int CntW      = $clog2(DivSteps);

  typedef enum logic [1:0] {
    CMD_MOVE   = 2'd0,
    CMD_OFFSET = 2'd1,
    CMD_SET    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]              command;
    logic [1:0]              direction;
    logic signed [StepW-1:0] step_count;
    logic [CoordW-1:0]       coordinate_value;
  } in_req_t;

  typedef struct packed {
    logic [CoordW-1:0] coord_0;
    logic [CoordW-1:0] coord_1;
    logic [CoordW-1:0] coord_2;
    logic [CoordW-1:0] coord_3;
    logic              range_error;
  } out_rsp_t;

  // extent zero counts as one, anything above the maximum saturates
  function automatic logic [ExtW-1:0] eff_extent(input logic [ExtW-1:0] raw);
    logic [ExtW-1:0] e;
    e = raw;
    if (raw == '0) begin
      e = ExtW'(1);
    end else if (raw > ExtW'(MaxExtent)) begin
      e = ExtW'(MaxExtent);
    end
    return e;
  endfunction

endpackage

>>> design/periodic_lattice_site_stepper_unit.sv
// move and offset requests run from accept through the bit-serial remainder unit
// (one quotient bit per cycle) and then the final step that registers the result;
// set and unused commands go straight to the final step; one request in flight at a time
// a new request is taken only after the result of the last one has been registered,
// later while a stalled result holds the block in its last step
// reset: asynchronous active low, extents return to 8 and all coordinates to zero
module periodic_lattice_site_stepper_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [plss_pkg::ExtW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  plss_pkg::in_req_t         in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output plss_pkg::out_rsp_t        out_rsp_o
);
  import plss_pkg::*;

  state_e              state_q, state_d;
  logic [ExtW-1:0]     extent_q [Dims];
  logic [CoordW-1:0]   coord_q  [Dims];
  logic [CoordW-1:0]   coord_d  [Dims];
  logic [1:0]          cmd_q, cmd_d;
  logic [1:0]          dir_q, dir_d;
  logic [CoordW-1:0]   val_q, val_d;
  logic [ExtW-1:0]     ext_q, ext_d;
  logic                neg_q, neg_d;
  logic [StepW-1:0]    dvd_q, dvd_d;
  logic [ExtW-1:0]     rem_q, rem_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  out_rsp_t            out_q, out_d;

  logic                accept;
  logic                out_free;
  logic signed [StepW:0] sum;
  logic [StepW:0]      sum_neg;
  logic [ExtW:0]       trial;
  logic [ExtW:0]       diff;
  logic [ExtW-1:0]     wrapped;
  logic [CoordW-1:0]   view [Dims];
  logic                err;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // signed sum of stored coordinate and step, then its magnitude
  assign sum     = $signed({{(StepW+1-CoordW){1'b0}}, coord_q[in_req_i.direction]})
                   + $signed({in_req_i.step_count[StepW-1], in_req_i.step_count});
  assign sum_neg = (StepW+1)'(-sum);

  // one restoring remainder step
  assign trial = {rem_q, dvd_q[StepW-1]};
  assign diff  = trial - {1'b0, ext_q};

  // floor modulo fix-up for a negative sum
  assign wrapped = (neg_q && rem_q != '0) ? (ext_q - rem_q) : rem_q;

  // extent registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Dims; i++) begin
        extent_q[i] <= ExtW'(ExtReset);
      end
    end else if (cfg_we_i) begin
      extent_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // control and site state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      for (int i = 0; i < Dims; i++) begin
        coord_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      coord_q     <= coord_d;
    end
  end

  // request and datapath registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    dir_q <= dir_d;
    val_q <= val_d;
    ext_q <= ext_d;
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  // sequencer and result assembly
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    dir_d       = dir_q;
    val_d       = val_q;
    ext_d       = ext_q;
    neg_d       = neg_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    coord_d     = coord_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    view        = coord_q;
    err         = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d = in_req_i.command;
          dir_d = in_req_i.direction;
          val_d = in_req_i.coordinate_value;
          ext_d = eff_extent(extent_q[in_req_i.direction]);
          neg_d = sum[StepW];
          dvd_d = sum[StepW] ? sum_neg[StepW-1:0] : sum[StepW-1:0];
          rem_d = '0;
          cnt_d = '0;
          if (in_req_i.command == CMD_MOVE || in_req_i.command == CMD_OFFSET) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        rem_d = (trial >= {1'b0, ext_q}) ? diff[ExtW-1:0] : trial[ExtW-1:0];
        dvd_d = {dvd_q[StepW-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        case (cmd_q)
          CMD_MOVE: begin
            coord_d[dir_q] = wrapped[CoordW-1:0];
            view[dir_q]    = wrapped[CoordW-1:0];
          end
          CMD_OFFSET: begin
            view[dir_q] = wrapped[CoordW-1:0];
          end
          CMD_SET: begin
            if ({1'b0, val_q} < ext_q) begin
              coord_d[dir_q] = val_q;
              view[dir_q]    = val_q;
            end else begin
              err = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (out_free) begin
          out_d.coord_0     = view[0];
          out_d.coord_1     = view[1];
          out_d.coord_2     = view[2];
          out_d.coord_3     = view[3];
          out_d.range_error = err;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          coord_d = coord_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/plss_checker.sv
module plss_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input plss_pkg::out_rsp_t        out_rsp_o
);

  // a pending result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_rsp_o))
    else $error("result payload changed while stalled");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a request");

  // no result appears in the cycle right after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // a new result comes with the block back to idle
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result issued while still busy");

endmodule

bind periodic_lattice_site_stepper_unit plss_checker u_plss_checker (.*);

>>> tb/periodic_lattice_site_stepper_unit_test.sv
module periodic_lattice_site_stepper_unit_test;

  import plss_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int PhaseCount = 6;
  localparam int PhaseItems = 100;
  localparam int MaxReports = 100;

  // register indexes of the extent registers
  localparam logic [1:0] EXT_DIM0 = 2'd0;
  localparam logic [1:0] EXT_DIM1 = 2'd1;
  localparam logic [1:0] EXT_DIM2 = 2'd2;
  localparam logic [1:0] EXT_DIM3 = 2'd3;

  typedef struct {
    bit              cfg;
    logic [1:0]      idx;
    logic [ExtW-1:0] val;
    in_req_t         req;
    bit              typed;
    out_rsp_t        rsp;
  } stim_row_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cfg_we    = 1'b0;
  logic [1:0]      cfg_idx   = '0;
  logic [ExtW-1:0] cfg_data  = '0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  in_req_t         in_req    = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_rsp_t        out_rsp;

  // predictor state: extents as written and the current site
  logic [ExtW-1:0]   ext_cfg  [Dims];
  logic [CoordW-1:0] site_pos [Dims];

  out_rsp_t  site_due [$];
  stim_row_t dir_tab [$];

  int  mismatch_cnt = 0;
  int  rsp_cnt      = 0;
  int  cyc          = 0;
  bit  tx_calm      = 1'b0;
  bit  rx_calm      = 1'b0;
  int  rx_stall     = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;

  periodic_lattice_site_stepper_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cyc++;
    if (cyc >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // extent actually used for wrapping and range checks
  function automatic int extent_in_use(input logic [ExtW-1:0] raw);
    int e;
    e = int'(raw);
    if (e == 0) begin
      e = 1;
    end else if (e > MaxExtent) begin
      e = MaxExtent;
    end
    return e;
  endfunction

  // floor modulo of stored coordinate plus step
  function automatic logic [CoordW-1:0] wrapped_coord(input int d,
                                                      input logic signed [StepW-1:0] s);
    int lim;
    int total;
    int rem;
    lim   = extent_in_use(ext_cfg[d]);
    total = int'(site_pos[d]) + int'(s);
    rem   = total % lim;
    if (rem < 0) begin
      rem += lim;
    end
    return rem[CoordW-1:0];
  endfunction

  // apply one request to the site and return the coordinates it reports
  function automatic out_rsp_t advance_site(input in_req_t r);
    int                d;
    logic [CoordW-1:0] view [Dims];
    out_rsp_t          o;
    d = int'(r.direction);
    o = '0;
    case (cmd_e'(r.command))
      CMD_MOVE: begin
        site_pos[d] = wrapped_coord(d, r.step_count);
      end
      CMD_SET: begin
        if (int'(r.coordinate_value) < extent_in_use(ext_cfg[d])) begin
          site_pos[d] = r.coordinate_value;
        end else begin
          o.range_error = 1'b1;
        end
      end
      default: ;
    endcase
    view = site_pos;
    if (cmd_e'(r.command) == CMD_OFFSET) begin
      view[d] = wrapped_coord(d, r.step_count);
    end
    o.coord_0 = view[0];
    o.coord_1 = view[1];
    o.coord_2 = view[2];
    o.coord_3 = view[3];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports) begin
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cyc, what, got, want);
    end
  endtask

  task automatic check_rsp(input out_rsp_t got);
    out_rsp_t want;
    rsp_cnt++;
    if (site_due.size() == 0) begin
      report_mismatch("result with no request pending, coord_0", got.coord_0, 0);
    end else begin
      want = site_due.pop_front();
      if (got.coord_0 !== want.coord_0) report_mismatch("coord_0", got.coord_0, want.coord_0);
      if (got.coord_1 !== want.coord_1) report_mismatch("coord_1", got.coord_1, want.coord_1);
      if (got.coord_2 !== want.coord_2) report_mismatch("coord_2", got.coord_2, want.coord_2);
      if (got.coord_3 !== want.coord_3) report_mismatch("coord_3", got.coord_3, want.coord_3);
      if (got.range_error !== want.range_error) begin
        report_mismatch("range_error", got.range_error, want.range_error);
      end
    end
  endtask

  // idle length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls, one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        check_rsp(out_rsp);
      end
      if (cyc % 300 == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      if (!hold_done && rsp_cnt == 40) begin
        hold_left = 200;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 99) < 15) begin
          rx_stall = idle_len();
        end
      end
    end
  end

  // offer one request, record its expectation once accepted
  task automatic push_req(input in_req_t r, input bit typed, input out_rsp_t typed_rsp);
    int       gap;
    out_rsp_t want;
    gap = tx_calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    want = advance_site(r);
    site_due.push_back(typed ? typed_rsp : want);
  endtask

  // wait until every result is back and the block is idle
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (site_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_extent(input logic [1:0] idx, input logic [ExtW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    ext_cfg[idx] = val;
    @(posedge clk);
  endtask

  function automatic in_req_t make_req(input cmd_e c, input int d, input int s, input int v);
    in_req_t r;
    r.command          = c;
    r.direction        = d[1:0];
    r.step_count       = s[StepW-1:0];
    r.coordinate_value = v[CoordW-1:0];
    return r;
  endfunction

  function automatic stim_row_t req_row(input cmd_e c, input int d, input int s, input int v);
    stim_row_t t;
    t       = '{default: '0};
    t.req   = make_req(c, d, s, v);
    return t;
  endfunction

  function automatic stim_row_t chk_row(input cmd_e c, input int d, input int s, input int v,
                                        input int c0, input int c1, input int c2,
                                        input int c3, input bit e);
    stim_row_t t;
    t       = req_row(c, d, s, v);
    t.typed = 1'b1;
    t.rsp   = '{coord_0: c0[7:0], coord_1: c1[7:0], coord_2: c2[7:0], coord_3: c3[7:0],
                range_error: e};
    return t;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input int val);
    stim_row_t t;
    t     = '{default: '0};
    t.cfg = 1'b1;
    t.idx = idx;
    t.val = val[ExtW-1:0];
    return t;
  endfunction

  // extent for a random phase: the extremes first, then random, often small
  function automatic logic [ExtW-1:0] phase_extent(input int ph);
    int r;
    case (ph)
      0: return ExtW'(MaxExtent);
      1: return ExtW'(1);
      2: return ($urandom_range(0, 1) != 0) ? ExtW'(0) : ExtW'(511);
      default: begin
        r = $urandom_range(0, 9);
        if (r == 0) return ExtW'(0);
        if (r == 1) return ExtW'($urandom_range(MaxExtent + 1, 511));
        if (r < 6) return ExtW'($urandom_range(1, 16));
        return ExtW'($urandom_range(17, MaxExtent));
      end
    endcase
  endfunction

  function automatic in_req_t random_req();
    in_req_t r;
    int      k;
    int      lim;
    int      d;
    k = $urandom_range(0, 99);
    d = $urandom_range(0, Dims - 1);
    r = '0;
    r.direction = d[1:0];
    if (k < 40) r.command = CMD_MOVE;
    else if (k < 70) r.command = CMD_OFFSET;
    else if (k < 95) r.command = CMD_SET;
    else r.command = CMD_NONE;
    // step: small half of the time, sometimes full range or an extreme
    k = $urandom_range(0, 99);
    if (k < 50) begin
      r.step_count = StepW'($urandom_range(0, 64) - 32);
    end else if (k < 85) begin
      r.step_count = StepW'($urandom());
    end else begin
      case ($urandom_range(0, 3))
        0: r.step_count = 16'sh8000;
        1: r.step_count = 16'sh7fff;
        2: r.step_count = -16'sd1;
        default: r.step_count = '0;
      endcase
    end
    // set value: anywhere, within the extent, or right at its edge
    lim = extent_in_use(ext_cfg[d]);
    k   = $urandom_range(0, 99);
    if (k < 50) begin
      r.coordinate_value = CoordW'($urandom_range(0, 255));
    end else if (k < 85) begin
      r.coordinate_value = CoordW'($urandom_range(0, lim - 1));
    end else begin
      r.coordinate_value = (lim > 255) ? CoordW'(255) : CoordW'(lim);
    end
    return r;
  endfunction

  initial begin
    stim_row_t row;
    out_rsp_t  none;
    none = '0;
    for (int i = 0; i < Dims; i++) begin
      ext_cfg[i]  = ExtW'(ExtReset);
      site_pos[i] = '0;
    end

    // after reset, extents of eight
    dir_tab.push_back(chk_row(CMD_SET,    0, 0,      255, 0, 0, 0, 0, 1'b1));
    dir_tab.push_back(chk_row(CMD_SET,    1, 0,      8,   0, 0, 0, 0, 1'b1));
    dir_tab.push_back(chk_row(CMD_SET,    2, 0,      7,   0, 0, 7, 0, 1'b0));
    dir_tab.push_back(chk_row(CMD_MOVE,   0, 1,      0,   1, 0, 7, 0, 1'b0));
    dir_tab.push_back(chk_row(CMD_MOVE,   0, -1,     0,   0, 0, 7, 0, 1'b0));
    dir_tab.push_back(req_row(CMD_MOVE,   0, -32768, 0));
    dir_tab.push_back(req_row(CMD_MOVE,   3, 32767,  0));
    dir_tab.push_back(req_row(CMD_OFFSET, 1, -3,     0));
    dir_tab.push_back(chk_row(CMD_NONE,   2, 5,      200, 0, 0, 7, 7, 1'b0));
    dir_tab.push_back(req_row(CMD_OFFSET, 2, 1,      0));
    dir_tab.push_back(req_row(CMD_SET,    1, 0,      0));
    // zero extent, full extent, saturated extent, extent below a stored coordinate
    dir_tab.push_back(cfg_row(EXT_DIM0, 0));
    dir_tab.push_back(cfg_row(EXT_DIM1, MaxExtent));
    dir_tab.push_back(cfg_row(EXT_DIM2, 511));
    dir_tab.push_back(cfg_row(EXT_DIM3, 3));
    dir_tab.push_back(chk_row(CMD_MOVE,   0, 12345,  0,   0, 0, 7, 7, 1'b0));
    dir_tab.push_back(chk_row(CMD_SET,    0, 0,      1,   0, 0, 7, 7, 1'b1));
    dir_tab.push_back(req_row(CMD_SET,    0, 0,      0));
    dir_tab.push_back(req_row(CMD_SET,    1, 0,      255));
    dir_tab.push_back(req_row(CMD_MOVE,   1, 1,      0));
    dir_tab.push_back(req_row(CMD_SET,    2, 0,      255));
    dir_tab.push_back(req_row(CMD_MOVE,   2, -256,   0));
    dir_tab.push_back(req_row(CMD_OFFSET, 3, 0,      0));
    dir_tab.push_back(req_row(CMD_SET,    3, 0,      3));
    dir_tab.push_back(req_row(CMD_MOVE,   3, -8,     0));
    dir_tab.push_back(req_row(CMD_OFFSET, 1, -32768, 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.cfg) begin
        settle_idle();
        write_extent(row.idx, row.val);
      end else begin
        push_req(row.req, row.typed, row.rsp);
      end
    end

    // random phases, each under its own extents
    for (int ph = 0; ph < PhaseCount; ph++) begin
      settle_idle();
      for (int i = 0; i < Dims; i++) begin
        write_extent(i[1:0], phase_extent(ph));
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 40 == 0) begin
          tx_calm = ($urandom_range(0, 3) == 0);
        end
        push_req(random_req(), 1'b0, none);
      end
    end

    settle_idle();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/plss_pkg.sv
design/periodic_lattice_site_stepper_unit.sv
design/plss_checker.sv
tb/periodic_lattice_site_stepper_unit_test.sv
